FILE: rtl/wvsd_pkg.sv
// Shared constants, register codes and sequencer states for the window variance
// still detector.
// Depends on nothing.
package wvsd_pkg;

   localparam int WINDOW_LEN = 32;

   localparam int SAMPLE_W = 16;
   localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W    = SAMPLE_W + SLOT_W;
   localparam int SQ_W     = 2 * SAMPLE_W - 1 + SLOT_W;
   localparam int NN_W     = 2 * CNT_W;
   localparam int VLIM_W   = 32;
   localparam int OLIM_W   = 16;

   localparam int A_W = ((SQ_W > VLIM_W) ? SQ_W : VLIM_W) + 1;
   localparam int B_W = ((SUM_W > NN_W) ? SUM_W : NN_W) + 1;
   localparam int P_W = A_W + B_W;

   localparam int WCOUNT_W = 6;
   localparam int WSUM_W   = 21;
   localparam int SCALED_W = 41;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_STATIC_GRAVITY = 2'd0,
      REG_VARIANCE_LIMIT = 2'd1,
      REG_OFFSET_LIMIT   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OLD,
      S_NEW,
      S_SUM,
      S_SCALE,
      S_NN,
      S_BOUND,
      S_CMP
   } state_type;

endpackage

FILE: rtl/window_variance_still_detector.sv
// Window variance still detector: sample ring, running sums and one shared multiplier
// stepped by a small sequencer; APB-style register port. Depends on wvsd_pkg.
// The result beat loads in S_CMP after S_OLD, S_NEW, S_SUM, S_SCALE, S_NN and S_BOUND.
// Samples are taken only in S_IDLE, after the result loads; six products per item.
// Reset (synchronous, active high) empties the window, clears the sums, the
// registers and the result valid; ring entries are undefined until written.
module window_variance_still_detector
   import wvsd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SAMPLE_W-1:0]  req_accel_z,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_is_still,
   output logic                        rsp_variance_over,
   output logic                        rsp_offset_over,
   output logic [WCOUNT_W-1:0]         rsp_window_count,
   output logic signed [WSUM_W-1:0]    rsp_window_sum,
   output logic [SCALED_W-1:0]         rsp_scaled_variance,

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] mem [WINDOW_LEN];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [CNT_W-1:0]           count_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [SQ_W-1:0]            sumsq_ff;
   logic signed [P_W-1:0]      prod_ff;
   logic signed [P_W-1:0]      sq_ff;
   logic signed [P_W-1:0]      scaled_ff;

   logic signed [SAMPLE_W-1:0] gravity_ff;
   logic [VLIM_W-1:0]          vlimit_ff;
   logic [OLIM_W-1:0]          olimit_ff;

   logic                       rsp_valid_ff;
   logic                       is_still_ff;
   logic                       var_over_ff;
   logic                       off_over_ff;
   logic [WCOUNT_W-1:0]        count_out_ff;
   logic signed [WSUM_W-1:0]   sum_out_ff;
   logic [SCALED_W-1:0]        scaled_out_ff;

   logic                       accept;
   logic                       full;
   logic signed [SAMPLE_W-1:0] old_s;
   logic                       mul_en;
   logic                       out_load;
   logic signed [A_W-1:0]      op_a;
   logic signed [B_W-1:0]      op_b;
   logic signed [P_W-1:0]      mul_out;
   logic signed [SAMPLE_W:0]   delta;
   logic [SAMPLE_W:0]          abs_dist;
   logic                       var_over;
   logic                       off_over;
   logic                       csr_wr;
   reg_index_type              csr_idx;

   assign accept = req_valid && req_ready;
   assign full   = (count_ff == CNT_W'(WINDOW_LEN));
   assign old_s  = full ? rd_ff : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_OLD;
         S_OLD:   state_in = S_NEW;
         S_NEW:   state_in = S_SUM;
         S_SUM:   state_in = S_SCALE;
         S_SCALE: state_in = S_NN;
         S_NN:    state_in = S_BOUND;
         S_BOUND: state_in = S_CMP;
         S_CMP:   if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: ready, result load and operand select for the shared multiplier
   always_comb begin
      req_ready = 1'b0;
      mul_en    = 1'b0;
      out_load  = 1'b0;
      op_a      = '0;
      op_b      = '0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_OLD: begin
            mul_en = 1'b1;
            op_a   = A_W'(old_s);
            op_b   = B_W'(old_s);
         end
         S_NEW: begin
            mul_en = 1'b1;
            op_a   = A_W'(x_ff);
            op_b   = B_W'(x_ff);
         end
         S_SUM: begin
            mul_en = 1'b1;
            op_a   = A_W'(sum_ff);
            op_b   = B_W'(sum_ff);
         end
         S_SCALE: begin
            mul_en = 1'b1;
            op_a   = A_W'(sumsq_ff);
            op_b   = B_W'(count_ff);
         end
         S_NN: begin
            mul_en = 1'b1;
            op_a   = A_W'(count_ff);
            op_b   = B_W'(count_ff);
         end
         S_BOUND: begin
            mul_en = 1'b1;
            op_a   = A_W'(vlimit_ff);
            op_b   = prod_ff[B_W-1:0];
         end
         S_CMP: out_load = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (state_ff == S_OLD) begin
         mem[slot_ff] <= x_ff;
      end
      rd_ff <= mem[slot_ff];
   end

   assign mul_out = P_W'(op_a * op_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_out;
      end
      if (accept) begin
         x_ff <= req_accel_z;
      end
      if (state_ff == S_SCALE) begin
         sq_ff <= prod_ff;
      end
      if (state_ff == S_NN) begin
         scaled_ff <= prod_ff - sq_ff;
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else begin
         unique case (state_ff)
            S_OLD: begin
               sum_ff  <= sum_ff - SUM_W'(old_s);
               slot_ff <= (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
               if (!full) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            S_NEW: begin
               sum_ff   <= sum_ff + SUM_W'(x_ff);
               sumsq_ff <= sumsq_ff - SQ_W'(prod_ff);
            end
            S_SUM:   sumsq_ff <= sumsq_ff + SQ_W'(prod_ff);
            default: sumsq_ff <= sumsq_ff;
         endcase
      end
   end

   // compare and result beat
   assign delta    = (SAMPLE_W + 1)'(x_ff) - (SAMPLE_W + 1)'(gravity_ff);
   assign abs_dist = delta[SAMPLE_W] ? (SAMPLE_W + 1)'(-delta) : (SAMPLE_W + 1)'(delta);
   assign off_over = abs_dist > (SAMPLE_W + 1)'(olimit_ff);
   assign var_over = scaled_ff > prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         is_still_ff   <= !var_over && !off_over;
         var_over_ff   <= var_over;
         off_over_ff   <= off_over;
         count_out_ff  <= WCOUNT_W'(count_ff);
         sum_out_ff    <= WSUM_W'(sum_ff);
         scaled_out_ff <= SCALED_W'(scaled_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_still        = is_still_ff;
   assign rsp_variance_over   = var_over_ff;
   assign rsp_offset_over     = off_over_ff;
   assign rsp_window_count    = count_out_ff;
   assign rsp_window_sum      = sum_out_ff;
   assign rsp_scaled_variance = scaled_out_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= '0;
         vlimit_ff  <= '0;
         olimit_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_STATIC_GRAVITY: gravity_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_VARIANCE_LIMIT: vlimit_ff  <= csr_pwdata[VLIM_W-1:0];
            REG_OFFSET_LIMIT:   olimit_ff  <= csr_pwdata[OLIM_W-1:0];
            default:            olimit_ff  <= olimit_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_STATIC_GRAVITY: csr_prdata = CSR_DATA_W'(gravity_ff);
         REG_VARIANCE_LIMIT: csr_prdata = CSR_DATA_W'(vlimit_ff);
         REG_OFFSET_LIMIT:   csr_prdata = CSR_DATA_W'(olimit_ff);
         default:            csr_prdata = '0;
      endcase
   end

endmodule
